[hw/rtl/bslpf_pkg.sv]
`timescale 1ns / 1ps

package bslpf_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CMD_OVERHEAD = 16'd4;
    localparam logic [7:0]  HEADER_RESET = 8'h80;
    localparam logic [7:0]  COMMAND_RESET = 8'h1B;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND = 8'd1;

    // one input byte after classification by the front end
    typedef struct packed {
        logic [7:0]  data;
        logic [23:0] addr;
        logic [8:0]  len;
        logic        first;
        logic        last;
    } t_item;

    // MSB-first CRC-16-CCITT over one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [15:0] c;
        c = crc_in ^ {byte_in, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/bslpf_if.sv]
`timescale 1ns / 1ps

interface bslpf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [23:0] block_address;
    logic [8:0]  block_length;

    modport source (output valid, output data_byte, output block_address,
                    output block_length, input ready);
    modport sink   (input valid, input data_byte, input block_address,
                    input block_length, output ready);
endinterface

interface bslpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;

    modport source (output valid, output out_byte, output run_last,
                    output packet_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input packet_end, output ready);
endinterface

interface bslpf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bslpf_pkg::CFG_IDX_W-1:0]    index;
    logic [7:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/bslpf_front.sv]
`timescale 1ns / 1ps

module bslpf_front #(
    parameter int MAX_BLOCK_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bslpf_in_if.sink          i_in,
    input  logic              i_q_full,
    output logic              o_q_push,
    output bslpf_pkg::t_item  o_q_item
);

    localparam logic [8:0] LEN_CAP = (MAX_BLOCK_BYTES > 511) ? 9'd511
                                                              : 9'(MAX_BLOCK_BYTES);

    logic [8:0] r_left;
    logic [8:0] n_left;
    logic [8:0] len_eff;
    logic       first;
    logic       accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign first      = (r_left == 9'd0);

    always_comb begin
        priority if (i_in.block_length == 9'd0) begin
            len_eff = 9'd1;
        end else if (i_in.block_length > LEN_CAP) begin
            len_eff = LEN_CAP;
        end else begin
            len_eff = i_in.block_length;
        end
        n_left = first ? (len_eff - 9'd1) : (r_left - 9'd1);
    end

    always_comb begin
        o_q_push       = accept;
        o_q_item.data  = i_in.data_byte;
        o_q_item.addr  = i_in.block_address;
        o_q_item.len   = len_eff;
        o_q_item.first = first;
        o_q_item.last  = (n_left == 9'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 9'd0;
        end else if (accept) begin
            r_left <= n_left;
        end
    end

endmodule

[hw/rtl/bslpf_queue.sv]
`timescale 1ns / 1ps

module bslpf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bslpf_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output bslpf_pkg::t_item  o_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    bslpf_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");

endmodule

[hw/rtl/bslpf_back.sv]
`timescale 1ns / 1ps

module bslpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bslpf_cfg_if.sink         i_cfg,
    input  logic              i_q_valid,
    input  bslpf_pkg::t_item  i_q_item,
    output logic              o_q_pop,
    bslpf_out_if.source       o_out
);

    localparam logic [3:0] S_HDR  = 4'd0;
    localparam logic [3:0] S_LENL = 4'd1;
    localparam logic [3:0] S_LENH = 4'd2;
    localparam logic [3:0] S_CMD  = 4'd3;
    localparam logic [3:0] S_A0   = 4'd4;
    localparam logic [3:0] S_A1   = 4'd5;
    localparam logic [3:0] S_A2   = 4'd6;
    localparam logic [3:0] S_DATA = 4'd7;
    localparam logic [3:0] S_CKL  = 4'd8;
    localparam logic [3:0] S_CKH  = 4'd9;

    logic [7:0]  r_header;
    logic [7:0]  r_command;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [3:0]  r_step;
    logic [3:0]  cur_step;
    logic        r_busy;
    logic        adv;
    logic        pop;
    logic [7:0]  n_byte;
    logic [15:0] cmd_len;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_run_last;
    logic        r_out_packet_end;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= bslpf_pkg::HEADER_RESET;
            r_command <= bslpf_pkg::COMMAND_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == bslpf_pkg::REG_HEADER) begin
                r_header <= i_cfg.data;
            end
            if (i_cfg.index == bslpf_pkg::REG_COMMAND) begin
                r_command <= i_cfg.data;
            end
        end
    end

    // advance the sequencer whenever the queue holds an item and the output register frees up
    assign adv      = i_q_valid && (!r_out_valid || o_out.ready);
    assign cur_step = r_busy ? r_step : (i_q_item.first ? S_HDR : S_DATA);
    assign cmd_len  = {7'd0, i_q_item.len} + bslpf_pkg::CMD_OVERHEAD;
    assign pop      = adv && ((cur_step == S_DATA && !i_q_item.last) ||
                              (cur_step == S_CKH));
    assign o_q_pop  = pop;

    always_comb begin
        n_crc = r_crc;
        unique case (cur_step)
            S_HDR:   n_byte = r_header;
            S_LENL:  n_byte = cmd_len[7:0];
            S_LENH:  n_byte = cmd_len[15:8];
            S_CMD: begin
                n_byte = r_command;
                n_crc  = bslpf_pkg::crc_feed(bslpf_pkg::CRC_INIT, r_command);
            end
            S_A0: begin
                n_byte = i_q_item.addr[7:0];
                n_crc  = bslpf_pkg::crc_feed(r_crc, i_q_item.addr[7:0]);
            end
            S_A1: begin
                n_byte = i_q_item.addr[15:8];
                n_crc  = bslpf_pkg::crc_feed(r_crc, i_q_item.addr[15:8]);
            end
            S_A2: begin
                n_byte = i_q_item.addr[23:16];
                n_crc  = bslpf_pkg::crc_feed(r_crc, i_q_item.addr[23:16]);
            end
            S_DATA: begin
                n_byte = i_q_item.data;
                n_crc  = bslpf_pkg::crc_feed(r_crc, i_q_item.data);
            end
            S_CKL:   n_byte = r_crc[7:0];
            S_CKH: begin
                n_byte = r_crc[15:8];
                n_crc  = bslpf_pkg::CRC_INIT;
            end
            default: n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= S_HDR;
            r_crc  <= bslpf_pkg::CRC_INIT;
        end else if (adv) begin
            r_crc  <= n_crc;
            r_busy <= !pop;
            r_step <= cur_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte       <= n_byte;
            r_out_run_last   <= pop;
            r_out_packet_end <= (cur_step == S_CKH);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.packet_end = r_out_packet_end;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_packet_end) |-> r_out_run_last)
        else $error("packet end without run last");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && cur_step == S_CKH) |=> (r_crc == bslpf_pkg::CRC_INIT && !r_busy))
        else $error("crc not restored after checksum");

    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step != S_HDR && r_step <= S_CKH))
        else $error("sequencer resumed at an impossible step");

endmodule

[hw/rtl/bsl_packet_framer_crc16.sv]
`timescale 1ns / 1ps

// channel  dir  fields                                       handshake
// i_in     in   data_byte[7:0] block_address[23:0]           valid/ready
//               block_length[8:0]
// o_out    out  out_byte[7:0] run_last packet_end            valid/ready
// i_cfg    in   index[7:0] data[7:0] (0 header, 1 command)   valid/ready, ready always high
//
// A middle byte of a block produces one output byte per cycle unless output stalls hold it.
// The first byte of a block yields 8 output bytes (header, length, command, address, data)
// and the last byte 3 (data, CKL, CKH); the sequencer emits one byte per cycle unless stalled.
// A 4-entry queue parts input acceptance from the sequencer; output stalls fill it.
// Reset is synchronous, active low; it restores the registers and waits for a block start.

module bsl_packet_framer_crc16 #(
    parameter int MAX_BLOCK_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bslpf_in_if.sink      i_in,
    bslpf_cfg_if.sink     i_cfg,
    bslpf_out_if.source   o_out
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    bslpf_pkg::t_item q_wr_item;
    bslpf_pkg::t_item q_rd_item;

    bslpf_front #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_item (q_wr_item)
    );

    bslpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_wr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_rd_item)
    );

    bslpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_rd_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

[dv/bslpf_frame_checker.sv]
`timescale 1ns / 1ps

module bslpf_frame_checker #(
    parameter int MAX_BYTES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bslpf_in_if  i_in,
    bslpf_out_if i_out,
    bslpf_cfg_if i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_bytes_seen,
    output int   o_packets_seen
);

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       pkt_end;
    } t_frame_beat;

    t_frame_beat frame_q[$];

    logic [7:0]  hdr_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] crc_acc;
    logic [8:0]  bytes_left;
    int          fails;
    int          bytes_seen;
    int          packets_seen;

    // CCITT polynomial, MSB first, one data bit per shift
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ bslpf_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // work out every framed byte that one payload byte causes
    task automatic frame_byte(input logic [7:0] data, input logic [23:0] addr,
                              input logic [8:0] len);
        t_frame_beat beats[$];
        logic [8:0]  n;
        logic [15:0] cmd_len;
        if (bytes_left == 0) begin
            n = len;
            if (n == 0) begin
                n = 9'd1;
            end
            if (n > MAX_BYTES) begin
                n = 9'(MAX_BYTES);
            end
            bytes_left = n;
            cmd_len = 16'(n) + bslpf_pkg::CMD_OVERHEAD;
            crc_acc = bslpf_pkg::CRC_INIT;
            beats.push_back('{hdr_reg, 1'b0, 1'b0});
            beats.push_back('{cmd_len[7:0], 1'b0, 1'b0});
            beats.push_back('{cmd_len[15:8], 1'b0, 1'b0});
            beats.push_back('{cmd_reg, 1'b0, 1'b0});
            crc_acc = crc16_step(crc_acc, cmd_reg);
            for (int k = 0; k < 3; k++) begin
                beats.push_back('{addr[8*k +: 8], 1'b0, 1'b0});
                crc_acc = crc16_step(crc_acc, addr[8*k +: 8]);
            end
        end
        beats.push_back('{data, 1'b0, 1'b0});
        crc_acc = crc16_step(crc_acc, data);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
            beats.push_back('{crc_acc[7:0], 1'b0, 1'b0});
            beats.push_back('{crc_acc[15:8], 1'b0, 1'b1});
            crc_acc = bslpf_pkg::CRC_INIT;
        end
        beats[beats.size()-1].run_last = 1'b1;
        foreach (beats[k]) begin
            frame_q.push_back(beats[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_beat exp_beat;
        if (!i_rst_n) begin
            hdr_reg      = bslpf_pkg::HEADER_RESET;
            cmd_reg      = bslpf_pkg::COMMAND_RESET;
            crc_acc      = bslpf_pkg::CRC_INIT;
            bytes_left   = '0;
            fails        = 0;
            bytes_seen   = 0;
            packets_seen = 0;
            frame_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    bslpf_pkg::REG_HEADER:  hdr_reg = i_cfg.data;
                    bslpf_pkg::REG_COMMAND: cmd_reg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                frame_byte(i_in.data_byte, i_in.block_address, i_in.block_length);
            end
            if (i_out.valid && i_out.ready) begin
                bytes_seen++;
                if (i_out.packet_end) begin
                    packets_seen++;
                end
                if (frame_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item out_byte %02h run_last %0b packet_end %0b",
                             $time, i_out.out_byte, i_out.run_last, i_out.packet_end);
                end else begin
                    exp_beat = frame_q.pop_front();
                    if (i_out.out_byte !== exp_beat.value) begin
                        fails++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_beat.value, i_out.out_byte);
                    end
                    if (i_out.run_last !== exp_beat.run_last) begin
                        fails++;
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, exp_beat.run_last, i_out.run_last);
                    end
                    if (i_out.packet_end !== exp_beat.pkt_end) begin
                        fails++;
                        $display("%0t: packet_end expected %0b actual %0b",
                                 $time, exp_beat.pkt_end, i_out.packet_end);
                    end
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= frame_q.size();
        o_bytes_seen   <= bytes_seen;
        o_packets_seen <= packets_seen;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES = 7;
    localparam int TAIL_CYCLES  = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_BYTES    = 256;

    // indexes past the register file, written to check they are dropped
    localparam logic [bslpf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = bslpf_pkg::REG_COMMAND + 1'b1;
    localparam logic [bslpf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bslpf_in_if  in_ch();
    bslpf_out_if out_ch();
    bslpf_cfg_if cfg_ch();

    int fail_count;
    int pending;
    int bytes_seen;
    int packets_seen;
    int cycles = 0;
    int items_sent = 0;
    int reg_writes = 0;
    int hold_asked = 0;
    int hold_done = 0;
    bit burst = 1'b0;

    always #5 i_clk = ~i_clk;

    bsl_packet_framer_crc16 #(.MAX_BLOCK_BYTES(MAX_BYTES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    bslpf_frame_checker #(.MAX_BYTES(MAX_BYTES)) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .i_cfg          (cfg_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bytes_seen   (bytes_seen),
        .o_packets_seen (packets_seen)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d framed bytes still due", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // hold valid high after an item when the next one follows at once
    task automatic push_byte(input logic [7:0] d, input logic [23:0] a, input logic [8:0] l);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= d;
        in_ch.block_address <= a;
        in_ch.block_length  <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [bslpf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val, input bit close);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        reg_writes++;
        if (close) begin
            cfg_ch.valid <= 1'b0;
        end
    endtask

    // stop offering and wait until every framed byte is out
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic int block_bytes(input logic [8:0] len);
        if (len == 0) begin
            return 1;
        end
        return (len > MAX_BYTES) ? MAX_BYTES : int'(len);
    endfunction

    function automatic logic [8:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 9'd0;
        end else if (r < 85) begin
            return 9'($urandom_range(1, 8));
        end
        return 9'($urandom_range(9, 40));
    endfunction

    // address and length only count on the first byte; scramble them later on
    task automatic send_block(input logic [8:0] len, input logic [23:0] addr, input int n);
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                push_byte(8'($urandom), addr, len);
            end else begin
                push_byte(8'($urandom), 24'($urandom), 9'($urandom_range(0, 511)));
            end
        end
    endtask

    task automatic random_phase(input int target, input bit fast, input bit with_hold);
        int done_items;
        logic [8:0] len;
        int n;
        done_items = 0;
        burst = fast;
        if (with_hold) begin
            hold_asked++;
        end
        while (done_items < target) begin
            len = pick_len();
            n = block_bytes(len);
            send_block(len, 24'($urandom), n);
            done_items += n;
        end
    endtask

    // receiver: random gap per item, one long hold-off on request
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_done != hold_asked) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end
            gap = burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.block_address <= '0;
        in_ch.block_length  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of the registers, field extremes, zero length
        push_byte(8'h00, 24'h000000, 9'd1);
        push_byte(8'hFF, 24'hFFFFFF, 9'd0);
        push_byte(8'hA5, 24'h123456, 9'd3);
        push_byte(8'h5A, 24'hFFFFFF, 9'h1FF);
        push_byte(8'hFF, 24'h000000, 9'd0);
        drain();

        // all-zero registers; writes past the register file must be dropped
        cfg_write(bslpf_pkg::REG_HEADER, 8'h00, 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, 8'h00, 1'b0);
        cfg_write(REG_SPARE_LO, 8'h55, 1'b0);
        cfg_write(REG_SPARE_HI, 8'hAA, 1'b1);
        push_byte(8'h80, 24'h800001, 9'd2);
        push_byte(8'h01, 24'h7FFFFE, 9'd100);
        drain();

        // all-ones registers, then a write in the middle of a block
        cfg_write(bslpf_pkg::REG_HEADER, 8'hFF, 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, 8'hFF, 1'b1);
        burst = 1'b1;
        push_byte(8'h01, 24'h00FF00, 9'd4);
        push_byte(8'h80, 24'hABCDEF, 9'd7);
        drain();
        cfg_write(bslpf_pkg::REG_HEADER, 8'h3C, 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, 8'hC3, 1'b1);
        push_byte(8'h7E, 24'h0F0F0F, 9'd300);
        push_byte(8'hE7, 24'hF0F0F0, 9'd1);
        push_byte(8'h42, 24'h5A5A5A, 9'd1);
        drain();

        cfg_write(bslpf_pkg::REG_HEADER, 8'($urandom), 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, 8'($urandom), 1'b1);
        random_phase(40, 1'b0, 1'b1);
        drain();

        cfg_write(bslpf_pkg::REG_HEADER, 8'($urandom), 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, 8'($urandom), 1'b1);
        random_phase(40, 1'b1, 1'b0);
        drain();

        cfg_write(bslpf_pkg::REG_HEADER, bslpf_pkg::HEADER_RESET, 1'b0);
        cfg_write(bslpf_pkg::REG_COMMAND, bslpf_pkg::COMMAND_RESET, 1'b1);
        random_phase(40, 1'b0, 1'b0);
        // a length past the limit: the header carries the clamped command length
        push_byte(8'h3C, 24'($urandom), 9'h1FF);
        push_byte(8'hC3, 24'($urandom), 9'd1);
        push_byte(8'h99, 24'($urandom), 9'd0);
        drain();

        $display("Sent %0d payload bytes (lengths zero, 1..40 and clamped), %0d reg writes.",
                 items_sent, reg_writes);
        $display("Checked %0d framed bytes in %0d packets with stalls and a long hold-off.",
                 bytes_seen, packets_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[bsl_packet_framer_crc16.f]
hw/rtl/bslpf_pkg.sv
hw/rtl/bslpf_if.sv
hw/rtl/bslpf_front.sv
hw/rtl/bslpf_queue.sv
hw/rtl/bslpf_back.sv
hw/rtl/bsl_packet_framer_crc16.sv
dv/bslpf_frame_checker.sv
dv/tb_top.sv
